// ===== design/triangle_distortion_energy_defines.svh =====
// assertion macros for the triangle distortion energy block
// used by the top level only, no other dependencies
`ifndef TRIANGLE_DISTORTION_ENERGY_DEFINES_SVH
`define TRIANGLE_DISTORTION_ENERGY_DEFINES_SVH

// same-cycle implication under active-low reset
`define TDE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under active-low reset
`define TDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tde_pkg.sv =====
// shared widths, constants and beat types of the triangle distortion energy block
// no dependencies
`timescale 1ns / 1ps

package tde_pkg;

    localparam int CORNERS    = 3;
    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int MAG_W      = COORD_W;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int L2_W       = PROD_W + 1;
    localparam int CM_W       = PROD_W + 1;
    localparam int ROOT_W     = 33;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int SQ_REM_W   = ROOT_W + 3;
    localparam int DIV_REM_W  = ROOT_W + 1;
    localparam int QUOT_W     = 62;
    localparam int CFG_W      = 32;
    localparam int QPROD_W    = CFG_W + ROOT_W;
    localparam int ENERGY_W   = 63;
    localparam int TERM_W     = 64;
    localparam int SUM_W      = TERM_W + 2;

    // front (3) + root steps + divide setup + divide steps + tail (6)
    localparam int CORNER_DEPTH = 3 + ROOT_W + 1 + QUOT_W + 6;
    localparam int PIPE_DEPTH   = CORNER_DEPTH + 2;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
    localparam logic [ENERGY_W-1:0] QUOT_CLAMP = {1'b1, {QUOT_W{1'b0}}};

    typedef enum logic [0:0] {
        CFG_QUALITY_FLOOR  = 1'b0,
        CFG_HARDENING_GAIN = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_a_x;
        logic signed [COORD_W-1:0] vertex_a_y;
        logic signed [COORD_W-1:0] vertex_b_x;
        logic signed [COORD_W-1:0] vertex_b_y;
        logic signed [COORD_W-1:0] vertex_c_x;
        logic signed [COORD_W-1:0] vertex_c_y;
    } tde_vertex_t;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic                saturated;
        logic                degenerate_edge;
    } tde_result_t;

    typedef struct packed {
        logic [TERM_W-1:0]   base;
        logic [ENERGY_W-1:0] penalty;
        logic                overflow;
        logic                degen;
    } tde_corner_res_t;

endpackage

// ===== design/triangle_distortion_energy.sv =====
// Throughput: one triangle per cycle when not stalled; depth is set by the 33 root steps and the
// 62 divider steps of each corner lane, one bit per stage.
// A stalled result freezes the whole pipeline in place.
// Reset clears all valid bits and loads quality_floor = 0.3 and hardening_gain = 10.
`timescale 1ns / 1ps

// top level: input register, three corner lanes, summation and result register
// depends on tde_pkg, tde_corner and triangle_distortion_energy_defines.svh
`include "triangle_distortion_energy_defines.svh"

module triangle_distortion_energy #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  tde_pkg::cfg_index_t         cfg_index,
    input  logic [tde_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        vertex_valid,
    output logic                        vertex_stall,
    input  tde_pkg::tde_vertex_t        vertex,
    output logic                        result_valid,
    input  logic                        result_stall,
    output tde_pkg::tde_result_t        result
);
    import tde_pkg::*;

    localparam logic [CFG_W-1:0] QF_RESET = CFG_W'(((3 << FRAC_BITS) + 5) / 10);
    localparam logic [CFG_W-1:0] HG_RESET = CFG_W'(10 << FRAC_BITS);

    logic                  adv;
    logic                  accept;
    logic [CFG_W-1:0]      qf_reg;
    logic [CFG_W-1:0]      hg_reg;
    tde_vertex_t           vin_reg;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic signed [COORD_W-1:0] xs [CORNERS];
    logic signed [COORD_W-1:0] ys [CORNERS];
    tde_corner_res_t       cres [CORNERS];
    logic [TERM_W-1:0]     s_reg [CORNERS];
    logic                  ovf_reg;
    logic                  degen_reg;
    logic [SUM_W-1:0]      total;
    tde_result_t           result_next;
    tde_result_t           result_reg;
    logic                  result_valid_reg;

    // the whole pipe moves whenever the result register is free or being taken
    assign adv          = !result_valid_reg || !result_stall;
    assign vertex_stall = !adv;
    assign accept       = vertex_valid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qf_reg <= QF_RESET;
            hg_reg <= HG_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_QUALITY_FLOOR:  qf_reg <= cfg_data;
                CFG_HARDENING_GAIN: hg_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg        <= {valid_reg[PIPE_DEPTH-2:0], accept};
            result_valid_reg <= valid_reg[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vin_reg <= vertex;
        end
    end

    assign xs[0] = vin_reg.vertex_a_x;
    assign ys[0] = vin_reg.vertex_a_y;
    assign xs[1] = vin_reg.vertex_b_x;
    assign ys[1] = vin_reg.vertex_b_y;
    assign xs[2] = vin_reg.vertex_c_x;
    assign ys[2] = vin_reg.vertex_c_y;

    for (genvar k = 0; k < CORNERS; k++)
    begin : g_corner
        tde_corner #(
            .FRAC_BITS (FRAC_BITS)
        ) u_corner (
            .clk            (clk),
            .adv            (adv),
            .pk_x           (xs[k]),
            .pk_y           (ys[k]),
            .pi_x           (xs[(k + 1) % CORNERS]),
            .pi_y           (ys[(k + 1) % CORNERS]),
            .pj_x           (xs[(k + 2) % CORNERS]),
            .pj_y           (ys[(k + 2) % CORNERS]),
            .quality_floor  (qf_reg),
            .hardening_gain (hg_reg),
            .res            (cres[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < CORNERS; k++)
            begin
                s_reg[k] <= cres[k].base + TERM_W'(cres[k].penalty);
            end
            ovf_reg   <= cres[0].overflow || cres[1].overflow || cres[2].overflow;
            degen_reg <= cres[0].degen || cres[1].degen || cres[2].degen;
            result_reg <= result_next;
        end
    end

    // an overflow in any corner lane or in the sum pins the energy at the top
    always_comb
    begin
        total = SUM_W'(s_reg[0]) + SUM_W'(s_reg[1]) + SUM_W'(s_reg[2]);
        result_next.saturated       = ovf_reg || (total[SUM_W-1:ENERGY_W] != '0);
        result_next.energy          = result_next.saturated ? ENERGY_MAX
                                                            : total[ENERGY_W-1:0];
        result_next.degenerate_edge = degen_reg;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `TDE_ASSERT_IMPLIES(a_sat_pins_energy, clk, rst_n, result_valid_reg && result_reg.saturated, result_reg.energy == ENERGY_MAX, "saturated beat without clamped energy")
    `TDE_ASSERT_NEXT(a_stall_freezes_pipe, clk, rst_n, !adv, $stable(valid_reg), "pipeline moved during stall")
    `TDE_ASSERT_IMPLIES(a_result_from_pipe, clk, rst_n, $rose(result_valid_reg), $past(valid_reg[PIPE_DEPTH-1]), "result appeared without a beat in flight")

endmodule

// ===== design/tde_sqrt_step.sv =====
// one registered step of the digit-by-digit integer square root
// depends on tde_pkg
`timescale 1ns / 1ps

module tde_sqrt_step (
    input  logic                          clk,
    input  logic                          adv,
    input  logic [tde_pkg::SQ_REM_W-1:0]  acc_rem,
    input  logic [tde_pkg::ROOT_W-1:0]    acc_root,
    input  logic [tde_pkg::RAD_W-1:0]     acc_rad,
    output logic [tde_pkg::SQ_REM_W-1:0]  new_rem,
    output logic [tde_pkg::ROOT_W-1:0]    new_root,
    output logic [tde_pkg::RAD_W-1:0]     new_rad
);
    import tde_pkg::*;

    logic [SQ_REM_W-1:0] shifted;
    logic [SQ_REM_W-1:0] trial;
    logic [SQ_REM_W-1:0] rem_next;
    logic [ROOT_W-1:0]   root_next;
    logic [SQ_REM_W-1:0] rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [RAD_W-1:0]    rad_reg;

    always_comb
    begin
        shifted = {acc_rem[SQ_REM_W-3:0], acc_rad[RAD_W-1 -: 2]};
        trial   = SQ_REM_W'({acc_root, 2'b01});
        if (shifted >= trial)
        begin
            rem_next  = shifted - trial;
            root_next = {acc_root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = shifted;
            root_next = {acc_root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= {acc_rad[RAD_W-3:0], 2'b00};
        end
    end

    assign new_rem  = rem_reg;
    assign new_root = root_reg;
    assign new_rad  = rad_reg;

endmodule

// ===== design/tde_div_step.sv =====
// one registered step of the restoring divider, one quotient bit per step
// depends on tde_pkg
`timescale 1ns / 1ps

module tde_div_step (
    input  logic                           clk,
    input  logic                           adv,
    input  logic [tde_pkg::DIV_REM_W-1:0]  acc_rem,
    input  logic [tde_pkg::QUOT_W-1:0]     acc_nq,
    input  logic [tde_pkg::ROOT_W-1:0]     divisor,
    output logic [tde_pkg::DIV_REM_W-1:0]  new_rem,
    output logic [tde_pkg::QUOT_W-1:0]     new_nq
);
    import tde_pkg::*;

    logic [DIV_REM_W-1:0] trial;
    logic [DIV_REM_W-1:0] dvs;
    logic                 ge;
    logic [DIV_REM_W-1:0] rem_next;
    logic [DIV_REM_W-1:0] rem_reg;
    logic [QUOT_W-1:0]    nq_reg;

    // dividend bits leave at the top of nq while quotient bits enter at the bottom
    always_comb
    begin
        trial    = {acc_rem[DIV_REM_W-2:0], acc_nq[QUOT_W-1]};
        dvs      = {1'b0, divisor};
        ge       = trial >= dvs;
        rem_next = ge ? trial - dvs : trial;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg <= rem_next;
            nq_reg  <= {acc_nq[QUOT_W-2:0], ge};
        end
    end

    assign new_rem = rem_reg;
    assign new_nq  = nq_reg;

endmodule

// ===== design/tde_corner.sv =====
// per-corner lane: edge length, root, height quotient and penalty term
// depends on tde_pkg, tde_sqrt_step and tde_div_step
`timescale 1ns / 1ps

module tde_corner #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                adv,
    input  logic signed [tde_pkg::COORD_W-1:0]  pk_x,
    input  logic signed [tde_pkg::COORD_W-1:0]  pk_y,
    input  logic signed [tde_pkg::COORD_W-1:0]  pi_x,
    input  logic signed [tde_pkg::COORD_W-1:0]  pi_y,
    input  logic signed [tde_pkg::COORD_W-1:0]  pj_x,
    input  logic signed [tde_pkg::COORD_W-1:0]  pj_y,
    input  logic [tde_pkg::CFG_W-1:0]           quality_floor,
    input  logic [tde_pkg::CFG_W-1:0]           hardening_gain,
    output tde_pkg::tde_corner_res_t            res
);
    import tde_pkg::*;

    // |ff| of 2^MB or more always overflows ff*ff >> FRAC_BITS, so only the low MB bits are squared
    localparam int MB     = (ENERGY_W + FRAC_BITS + 1) / 2;
    localparam int HI_W   = MB - 32;
    localparam int LH_W   = 32 + HI_W;
    localparam int HH_W   = 2 * HI_W;
    localparam int MSQ_W  = 2 * MB + 1;
    localparam int PRD_W  = 96;
    localparam int LIM_SH = ENERGY_W + FRAC_BITS;

    typedef struct packed {
        logic [TERM_W-1:0] base;
        logic              degen;
        logic              cs;
        logic [CM_W-1:0]   cm;
    } sq_side_t;

    typedef struct packed {
        logic [TERM_W-1:0]  base;
        logic               degen;
        logic               cs;
        logic               big;
        logic [ROOT_W-1:0]  root;
        logic [QPROD_W-1:0] qprod;
    } dv_side_t;

    // front stage 1: differences and magnitudes
    logic signed [DIFF_W-1:0] ex, ey, dx, dy;
    logic signed [DIFF_W-1:0] ex_abs, ey_abs, dx_abs, dy_abs;
    logic [MAG_W-1:0] exm_reg, eym_reg, dxm_reg, dym_reg;
    logic             exn_reg, eyn_reg, dxn_reg, dyn_reg;

    // front stage 2: products
    logic [PROD_W-1:0] exsq_reg, eysq_reg, pm_reg, qm_reg;
    logic              ps_reg, qs_reg;

    // front stage 3: squared length and cross product
    logic [L2_W-1:0] l2;
    logic [CM_W-1:0] cm;
    logic            cs;
    logic [L2_W-1:0] l2_reg;

    sq_side_t sq_side_reg [0:ROOT_W];
    wire [SQ_REM_W-1:0] sq_rem  [0:ROOT_W];
    wire [ROOT_W-1:0]   sq_root [0:ROOT_W];
    wire [RAD_W-1:0]    sq_rad  [0:ROOT_W];

    // divide setup and steps
    logic                 big;
    logic [DIV_REM_W-1:0] d0_rem_reg;
    logic [QUOT_W-1:0]    d0_nq_reg;
    dv_side_t             dv_side_reg [0:QUOT_W];
    wire [DIV_REM_W-1:0]  dv_rem [0:QUOT_W];
    wire [QUOT_W-1:0]     dv_nq  [0:QUOT_W];

    // tail stages
    dv_side_t            dv_last;
    logic [ENERGY_W-1:0] quot;
    logic [ENERGY_W-1:0] qterm;
    logic [ENERGY_W-1:0] p1_sum_reg;
    logic [TERM_W-1:0]   p1_diff_reg;
    logic                p1_cs_reg, p1_degen_reg;
    logic [TERM_W-1:0]   p1_base_reg;

    logic [ENERGY_W-1:0] m_full;
    logic                pos_diff;
    logic [MB-1:0]       m_reg;
    logic                p2_big_reg, p2_on_reg, p2_degen_reg;
    logic [TERM_W-1:0]   p2_base_reg;

    logic [PROD_W-1:0]   pll_reg;
    logic [LH_W-1:0]     plh_reg;
    logic [HH_W-1:0]     phh_reg;
    logic                p3_big_reg, p3_on_reg, p3_degen_reg;
    logic [TERM_W-1:0]   p3_base_reg;

    logic [MSQ_W-1:0]    msq;
    logic [ENERGY_W-1:0] sq_reg;
    logic                p4_ovf_reg, p4_on_reg, p4_degen_reg;
    logic [TERM_W-1:0]   p4_base_reg;

    logic [PROD_W-1:0]   q0_reg;
    logic [PROD_W-1:0]   q1_reg;
    logic                p5_ovf_reg, p5_on_reg, p5_degen_reg;
    logic [TERM_W-1:0]   p5_base_reg;

    logic [PRD_W-1:0]    prod;
    logic                ovf_all;
    tde_corner_res_t     res_next;
    tde_corner_res_t     res_reg;

    always_comb
    begin
        ex = DIFF_W'(pi_x) - DIFF_W'(pk_x);
        ey = DIFF_W'(pi_y) - DIFF_W'(pk_y);
        dx = DIFF_W'(pj_x) - DIFF_W'(pk_x);
        dy = DIFF_W'(pj_y) - DIFF_W'(pk_y);
        ex_abs = ex[DIFF_W-1] ? -ex : ex;
        ey_abs = ey[DIFF_W-1] ? -ey : ey;
        dx_abs = dx[DIFF_W-1] ? -dx : dx;
        dy_abs = dy[DIFF_W-1] ? -dy : dy;
    end

    always_comb
    begin
        l2 = {1'b0, exsq_reg} + {1'b0, eysq_reg};
        // sign and magnitude of ex*dy - ey*dx
        if (ps_reg == qs_reg)
        begin
            cm = {1'b0, pm_reg} + {1'b0, qm_reg};
            cs = ps_reg;
        end
        else if (pm_reg >= qm_reg)
        begin
            cm = CM_W'(pm_reg - qm_reg);
            cs = ps_reg;
        end
        else
        begin
            cm = CM_W'(qm_reg - pm_reg);
            cs = qs_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            exm_reg <= ex_abs[MAG_W-1:0];
            eym_reg <= ey_abs[MAG_W-1:0];
            dxm_reg <= dx_abs[MAG_W-1:0];
            dym_reg <= dy_abs[MAG_W-1:0];
            exn_reg <= ex[DIFF_W-1];
            eyn_reg <= ey[DIFF_W-1];
            dxn_reg <= dx[DIFF_W-1];
            dyn_reg <= dy[DIFF_W-1];

            exsq_reg <= PROD_W'(exm_reg) * PROD_W'(exm_reg);
            eysq_reg <= PROD_W'(eym_reg) * PROD_W'(eym_reg);
            pm_reg   <= PROD_W'(exm_reg) * PROD_W'(dym_reg);
            qm_reg   <= PROD_W'(eym_reg) * PROD_W'(dxm_reg);
            ps_reg   <= exn_reg ^ dyn_reg;
            qs_reg   <= !(eyn_reg ^ dxn_reg);

            l2_reg               <= l2;
            sq_side_reg[0].base  <= TERM_W'(l2 >> FRAC_BITS);
            sq_side_reg[0].degen <= (l2 == '0);
            sq_side_reg[0].cs    <= cs;
            sq_side_reg[0].cm    <= cm;
            for (int g = 0; g < ROOT_W; g++)
            begin
                sq_side_reg[g+1] <= sq_side_reg[g];
            end
        end
    end

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = RAD_W'(l2_reg);

    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_sqrt
        tde_sqrt_step u_step (
            .clk      (clk),
            .adv      (adv),
            .acc_rem  (sq_rem[g]),
            .acc_root (sq_root[g]),
            .acc_rad  (sq_rad[g]),
            .new_rem  (sq_rem[g+1]),
            .new_root (sq_root[g+1]),
            .new_rad  (sq_rad[g+1])
        );
    end

    // quotient bits at 2^62 and up come from the top of cm alone; any of them clamps
    assign big = ROOT_W'(sq_side_reg[ROOT_W].cm[CM_W-1:QUOT_W]) >= sq_root[ROOT_W];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d0_rem_reg           <= DIV_REM_W'(sq_side_reg[ROOT_W].cm[CM_W-1:QUOT_W]);
            d0_nq_reg            <= sq_side_reg[ROOT_W].cm[QUOT_W-1:0];
            dv_side_reg[0].base  <= sq_side_reg[ROOT_W].base;
            dv_side_reg[0].degen <= sq_side_reg[ROOT_W].degen;
            dv_side_reg[0].cs    <= sq_side_reg[ROOT_W].cs;
            dv_side_reg[0].big   <= big;
            dv_side_reg[0].root  <= sq_root[ROOT_W];
            dv_side_reg[0].qprod <= QPROD_W'(quality_floor) * QPROD_W'(sq_root[ROOT_W]);
            for (int g = 0; g < QUOT_W; g++)
            begin
                dv_side_reg[g+1] <= dv_side_reg[g];
            end
        end
    end

    assign dv_rem[0] = d0_rem_reg;
    assign dv_nq[0]  = d0_nq_reg;

    for (genvar g = 0; g < QUOT_W; g++)
    begin : g_div
        tde_div_step u_step (
            .clk     (clk),
            .adv     (adv),
            .acc_rem (dv_rem[g]),
            .acc_nq  (dv_nq[g]),
            .divisor (dv_side_reg[g].root),
            .new_rem (dv_rem[g+1]),
            .new_nq  (dv_nq[g+1])
        );
    end

    always_comb
    begin
        dv_last = dv_side_reg[QUOT_W];
        quot    = dv_last.big ? QUOT_CLAMP : {1'b0, dv_nq[QUOT_W]};
        qterm   = ENERGY_W'(dv_last.qprod >> FRAC_BITS);
    end

    // ff < 0 reduces to a sum or a difference of the two magnitudes
    always_comb
    begin
        pos_diff = !p1_diff_reg[TERM_W-1] && (p1_diff_reg != '0);
        m_full   = p1_cs_reg ? p1_sum_reg : p1_diff_reg[ENERGY_W-1:0];
    end

    always_comb
    begin
        msq = MSQ_W'(pll_reg) + (MSQ_W'(plh_reg) << 33) + (MSQ_W'(phh_reg) << 64);
    end

    always_comb
    begin
        prod             = PRD_W'(q0_reg) + (PRD_W'(q1_reg) << 32);
        ovf_all          = p5_ovf_reg || ((prod >> LIM_SH) != '0);
        res_next.base    = p5_base_reg;
        res_next.penalty = (p5_on_reg && !ovf_all) ? prod[FRAC_BITS +: ENERGY_W] : '0;
        res_next.overflow = p5_on_reg && ovf_all;
        res_next.degen   = p5_degen_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_sum_reg   <= quot + qterm;
            p1_diff_reg  <= {1'b0, qterm} - {1'b0, quot};
            p1_cs_reg    <= dv_last.cs;
            p1_degen_reg <= dv_last.degen;
            p1_base_reg  <= dv_last.base;

            m_reg        <= m_full[MB-1:0];
            p2_big_reg   <= (m_full >> MB) != '0;
            p2_on_reg    <= !p1_degen_reg && (p1_cs_reg ? (p1_sum_reg != '0) : pos_diff);
            p2_degen_reg <= p1_degen_reg;
            p2_base_reg  <= p1_base_reg;

            pll_reg      <= PROD_W'(m_reg[31:0]) * PROD_W'(m_reg[31:0]);
            plh_reg      <= LH_W'(m_reg[31:0]) * LH_W'(m_reg[MB-1:32]);
            phh_reg      <= HH_W'(m_reg[MB-1:32]) * HH_W'(m_reg[MB-1:32]);
            p3_big_reg   <= p2_big_reg;
            p3_on_reg    <= p2_on_reg;
            p3_degen_reg <= p2_degen_reg;
            p3_base_reg  <= p2_base_reg;

            sq_reg       <= msq[FRAC_BITS +: ENERGY_W];
            p4_ovf_reg   <= p3_big_reg || ((msq >> LIM_SH) != '0);
            p4_on_reg    <= p3_on_reg;
            p4_degen_reg <= p3_degen_reg;
            p4_base_reg  <= p3_base_reg;

            q0_reg       <= PROD_W'(sq_reg[31:0]) * PROD_W'(hardening_gain);
            q1_reg       <= PROD_W'(sq_reg[ENERGY_W-1:32]) * PROD_W'(hardening_gain);
            p5_ovf_reg   <= p4_ovf_reg;
            p5_on_reg    <= p4_on_reg;
            p5_degen_reg <= p4_degen_reg;
            p5_base_reg  <= p4_base_reg;

            res_reg      <= res_next;
        end
    end

    assign res = res_reg;

endmodule
